// ----- design/cau_pkg.sv -----
package cau_pkg;

    // operand and result format
    localparam int DATA_W = 16;
    localparam int FRAC_W = 8;
    localparam int CMD_W  = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONJ = 3'd4;

    // internal widths
    localparam int PROD_W  = 2 * DATA_W;          // one product
    localparam int NUM_W   = PROD_W + 1;          // sum of two products
    localparam int DEN_W   = PROD_W;              // br^2 + bi^2
    localparam int VAL_W   = NUM_W - FRAC_W;      // pre-saturation value
    localparam int QUO_W   = DATA_W;              // quotient bits kept
    localparam int REM_W   = DEN_W + QUO_W;       // divider remainder
    localparam int DIV_LAT = QUO_W + 1;           // divider stages

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic signed [VAL_W-1:0] VAL_HI = VAL_W'((1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [VAL_W-1:0] VAL_LO = -VAL_HI - VAL_W'(1);
    localparam logic [QUO_W-1:0] QUO_MAXPOS = QUO_W'((1 << (DATA_W - 1)) - 1);
    localparam logic [QUO_W-1:0] QUO_MAXNEG = QUO_W'(1 << (DATA_W - 1));

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } t_item;

    // saturate a signed value; returns {overflow, result}
    function automatic logic [DATA_W:0] sat_val(input logic signed [VAL_W-1:0] v);
        logic [DATA_W:0] r;
        if (v > VAL_HI) begin
            r = {1'b1, VAL_HI[DATA_W-1:0]};
        end else if (v < VAL_LO) begin
            r = {1'b1, VAL_LO[DATA_W-1:0]};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

    // saturate sign/magnitude quotient; big means magnitude beyond QUO_W bits
    function automatic logic [DATA_W:0] sat_quo(input logic neg, input logic big,
                                                input logic [QUO_W-1:0] q);
        logic [DATA_W:0] r;
        if (!neg) begin
            if (big || q > QUO_MAXPOS) r = {1'b1, QUO_MAXPOS};
            else                       r = {1'b0, q};
        end else begin
            if (big || q > QUO_MAXNEG) r = {1'b1, QUO_MAXNEG};
            else                       r = {1'b0, (~q) + QUO_W'(1)};
        end
        return r;
    endfunction

endpackage

// ----- design/complex_arithmetic_unit.sv -----
// Channel   Dir  Word                              Sideband
// s_axis    in   tdata = a_re, a_im, b_re, b_im    tuser = command
// m_axis    out  tdata = res_re, res_im            tuser = overflow, div_zero
//
// One word accepted per cycle while the queue has room; each result leaves through stage A, stage B, the
// 17-stage restoring divider (one quotient bit a stage after the first) and an output register;
// every command passes through the divider so results stay in order.
// Reset (i_rst_n low, synchronous) empties the queue and the pipeline.
// A stalled output freezes the back pipeline; the 4-word queue keeps taking input until full.
module complex_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
    input  logic [2:0]  i_s_axis_tuser,   // command[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // res_re[15:0], res_im[31:16]
    output logic [1:0]  o_m_axis_tuser    // overflow[0], div_zero[1]
);

    cau_pkg::t_item in_item, q_item;
    logic           q_valid, q_pop;
    logic [cau_pkg::DATA_W-1:0] res_re, res_im;
    logic           ovf, dz;

    assign in_item.cmd  = i_s_axis_tuser;
    assign in_item.a_re = i_s_axis_tdata[15:0];
    assign in_item.a_im = i_s_axis_tdata[31:16];
    assign in_item.b_re = i_s_axis_tdata[47:32];
    assign in_item.b_im = i_s_axis_tdata[63:48];

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_item  (q_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_re    (res_re),
        .o_im    (res_im),
        .o_ovf   (ovf),
        .o_dz    (dz)
    );

    assign o_m_axis_tdata = {res_im, res_re};
    assign o_m_axis_tuser = {dz, ovf};

endmodule

// ----- design/cau_front.sv -----
module cau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cau_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output cau_pkg::t_item o_item
);

    cau_pkg::t_item               r_mem [0:cau_pkg::FIFO_DEPTH-1];
    logic [cau_pkg::FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [cau_pkg::FIFO_AW:0]    r_count;
    logic                         push, pop;
    cau_pkg::t_item               item_cl;

    // unused command codes become a plain zero result: fold them to add of zeros
    always_comb begin
        item_cl = i_item;
        if (i_item.cmd > cau_pkg::CMD_CONJ) begin
            item_cl.cmd  = cau_pkg::CMD_ADD;
            item_cl.a_re = '0;
            item_cl.a_im = '0;
            item_cl.b_re = '0;
            item_cl.b_im = '0;
        end
    end

    assign o_ready = (r_count != (cau_pkg::FIFO_AW + 1)'(cau_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_cl;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + cau_pkg::FIFO_AW'(1);
            if (pop)  r_rd_ptr <= r_rd_ptr + cau_pkg::FIFO_AW'(1);
            if (push && !pop)      r_count <= r_count + (cau_pkg::FIFO_AW + 1)'(1);
            else if (pop && !push) r_count <= r_count - (cau_pkg::FIFO_AW + 1)'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (cau_pkg::FIFO_AW + 1)'(cau_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- design/cau_divider.sv -----
module cau_divider (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [cau_pkg::NUM_W-1:0]  i_num,
    input  logic [cau_pkg::DEN_W-1:0]         i_den,
    output logic                              o_neg,
    output logic                              o_big,
    output logic [cau_pkg::QUO_W-1:0]         o_quo
);

    logic [cau_pkg::REM_W-1:0] r_rem [0:cau_pkg::QUO_W-1];
    logic [cau_pkg::DEN_W-1:0] r_den [0:cau_pkg::QUO_W-1];
    logic [cau_pkg::QUO_W-1:0] r_q   [0:cau_pkg::QUO_W];
    logic                      r_neg [0:cau_pkg::QUO_W];
    logic                      r_big [0:cau_pkg::QUO_W];

    logic                         neg_in;
    logic [cau_pkg::NUM_W-2:0]    mag_in;
    logic [cau_pkg::REM_W-1:0]    n_in;

    // magnitude, scaled numerator, early overflow check
    assign neg_in = i_num[cau_pkg::NUM_W-1];
    assign mag_in = neg_in ? (cau_pkg::NUM_W-1)'(-i_num) : i_num[cau_pkg::NUM_W-2:0];
    assign n_in   = cau_pkg::REM_W'({mag_in, cau_pkg::FRAC_W'(0)});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_in;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= neg_in;
            r_big[0] <= n_in >= {i_den, cau_pkg::QUO_W'(0)};
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= cau_pkg::QUO_W; k++) begin : g_stage
        localparam int SH = cau_pkg::QUO_W - k;
        logic [cau_pkg::REM_W-1:0] dsh;
        logic                      ge;
        assign dsh = cau_pkg::REM_W'(r_den[k-1]) << SH;
        assign ge  = r_rem[k-1] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {r_q[k-1][cau_pkg::QUO_W-2:0], ge};
                r_neg[k] <= r_neg[k-1];
                r_big[k] <= r_big[k-1];
            end
        end
        if (k < cau_pkg::QUO_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? r_rem[k-1] - dsh : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_neg = r_neg[cau_pkg::QUO_W];
    assign o_big = r_big[cau_pkg::QUO_W];
    assign o_quo = r_q[cau_pkg::QUO_W];

endmodule

// ----- design/cau_back.sv -----
module cau_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_pop,
    input  cau_pkg::t_item              i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cau_pkg::DATA_W-1:0]  o_re,
    output logic [cau_pkg::DATA_W-1:0]  o_im,
    output logic                        o_ovf,
    output logic                        o_dz
);

    typedef struct packed {
        logic                             is_div;
        logic                             dz;
        logic signed [cau_pkg::VAL_W-1:0] v_re;
        logic signed [cau_pkg::VAL_W-1:0] v_im;
    } t_side;

    logic en;

    // stage A: products
    logic                              r_va;
    cau_pkg::t_item                    r_a;
    logic signed [cau_pkg::PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_sr, r_p_si;

    // stage B: sums
    logic                              r_vb;
    t_side                             r_b;
    logic signed [cau_pkg::NUM_W-1:0]  r_num_re, r_num_im;
    logic [cau_pkg::DEN_W-1:0]         r_den;

    // divider span and output
    logic  r_vd [0:cau_pkg::DIV_LAT-1];
    t_side r_sd [0:cau_pkg::DIV_LAT-1];
    logic  r_vo;
    logic [cau_pkg::DATA_W-1:0] r_re, r_im;
    logic  r_ovf, r_dz;

    logic signed [cau_pkg::NUM_W-1:0] mr, mi, nr, ni;
    logic [cau_pkg::DEN_W-1:0]        den;
    t_side                            side_b;
    logic                             qneg_re, qbig_re, qneg_im, qbig_im;
    logic [cau_pkg::QUO_W-1:0]        quo_re, quo_im;
    logic [cau_pkg::DATA_W:0]         sat_re, sat_im;
    t_side                            last;

    assign en    = !r_vo || i_ready;
    assign o_pop = en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= i_item;
            r_p_rr <= i_item.a_re * i_item.b_re;
            r_p_ii <= i_item.a_im * i_item.b_im;
            r_p_ri <= i_item.a_re * i_item.b_im;
            r_p_ir <= i_item.a_im * i_item.b_re;
            r_p_sr <= i_item.b_re * i_item.b_re;
            r_p_si <= i_item.b_im * i_item.b_im;
        end
    end

    // exact sums and per-command value
    always_comb begin
        mr  = cau_pkg::NUM_W'(r_p_rr) - cau_pkg::NUM_W'(r_p_ii);
        mi  = cau_pkg::NUM_W'(r_p_ri) + cau_pkg::NUM_W'(r_p_ir);
        nr  = cau_pkg::NUM_W'(r_p_rr) + cau_pkg::NUM_W'(r_p_ii);
        ni  = cau_pkg::NUM_W'(r_p_ir) - cau_pkg::NUM_W'(r_p_ri);
        den = cau_pkg::DEN_W'($unsigned(r_p_sr)) + cau_pkg::DEN_W'($unsigned(r_p_si));
        side_b = '0;
        unique case (r_a.cmd)
            cau_pkg::CMD_ADD: begin
                side_b.v_re = cau_pkg::VAL_W'(r_a.a_re) + cau_pkg::VAL_W'(r_a.b_re);
                side_b.v_im = cau_pkg::VAL_W'(r_a.a_im) + cau_pkg::VAL_W'(r_a.b_im);
            end
            cau_pkg::CMD_SUB: begin
                side_b.v_re = cau_pkg::VAL_W'(r_a.a_re) - cau_pkg::VAL_W'(r_a.b_re);
                side_b.v_im = cau_pkg::VAL_W'(r_a.a_im) - cau_pkg::VAL_W'(r_a.b_im);
            end
            cau_pkg::CMD_MUL: begin
                side_b.v_re = cau_pkg::VAL_W'(mr >>> cau_pkg::FRAC_W);
                side_b.v_im = cau_pkg::VAL_W'(mi >>> cau_pkg::FRAC_W);
            end
            cau_pkg::CMD_DIV: begin
                side_b.is_div = 1'b1;
                side_b.dz     = (den == '0);
            end
            cau_pkg::CMD_CONJ: begin
                side_b.v_re = cau_pkg::VAL_W'(r_a.a_re);
                side_b.v_im = -cau_pkg::VAL_W'(r_a.a_im);
            end
            default: begin
                side_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b      <= side_b;
            r_num_re <= nr;
            r_num_im <= ni;
            r_den    <= den;
        end
    end

    cau_divider u_div_re (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_re),
        .i_den (r_den),
        .o_neg (qneg_re),
        .o_big (qbig_re),
        .o_quo (quo_re)
    );

    cau_divider u_div_im (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_im),
        .i_den (r_den),
        .o_neg (qneg_im),
        .o_big (qbig_im),
        .o_quo (quo_im)
    );

    // sideband runs alongside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_b;
            for (int k = 1; k < cau_pkg::DIV_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // final saturation
    assign last = r_sd[cau_pkg::DIV_LAT-1];
    always_comb begin
        if (last.is_div) begin
            sat_re = cau_pkg::sat_quo(qneg_re, qbig_re, quo_re);
            sat_im = cau_pkg::sat_quo(qneg_im, qbig_im, quo_im);
        end else begin
            sat_re = cau_pkg::sat_val(last.v_re);
            sat_im = cau_pkg::sat_val(last.v_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (last.dz) begin
                r_re  <= '0;
                r_im  <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_re  <= sat_re[cau_pkg::DATA_W-1:0];
                r_im  <= sat_im[cau_pkg::DATA_W-1:0];
                r_ovf <= sat_re[cau_pkg::DATA_W] | sat_im[cau_pkg::DATA_W];
            end
            r_dz <= last.dz;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k < cau_pkg::DIV_LAT; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (en) begin
            r_va    <= i_valid;
            r_vb    <= r_va;
            r_vd[0] <= r_vb;
            for (int k = 1; k < cau_pkg::DIV_LAT; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_vo <= r_vd[cau_pkg::DIV_LAT-1];
        end
    end

    assign o_valid = r_vo;
    assign o_re    = r_re;
    assign o_im    = r_im;
    assign o_ovf   = r_ovf;
    assign o_dz    = r_dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_dz |-> r_re == '0 && r_im == '0 && !r_ovf)
        else $error("divide by zero result not cleared");

    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vd[cau_pkg::DIV_LAT-1] && !last.is_div |=> !r_dz)
        else $error("zero divisor flag outside divide");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vb) && $stable(r_vd[cau_pkg::DIV_LAT-1]) && $stable(r_re))
        else $error("pipeline moved while stalled");

endmodule
